/* rtl/core/ktd_pkg.sv */
`timescale 1ns / 1ps
// Package for the keyboard text-entry decoder: types, codes, key map and
// dead-accent composition. No dependencies.
package ktd_pkg;

    localparam int CHAR_W      = 8;
    localparam int SCAN_W      = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;

    // Special decoder outputs
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'd24;
    localparam logic [CHAR_W-1:0] CH_ENTER = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACK  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_GRAVE = 8'h60;
    localparam logic [CHAR_W-1:0] CH_ACUTE = 8'hB4;
    localparam logic [CHAR_W-1:0] CH_CIRC  = 8'h5E;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_KEY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN   = 1'd1;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_ON      = 2'd2,
        KIND_OFF     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_FINISH = 3'd3,
        ACT_START  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LISTEN = 2'd1,
        MODE_ENTRY  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ACC_GRAVE = 2'd0,
        ACC_ACUTE = 2'd1,
        ACC_CIRC  = 2'd2
    } t_accent;

    // Held-key set commands
    typedef struct packed {
        logic add;
        logic release_key;
        logic clear;
    } t_held_cmd;

    // German layout, scan code set 1, to Windows-1252
    function automatic logic [CHAR_W-1:0] ktd_decode(input logic [SCAN_W-1:0] sc,
                                                     input logic sh,
                                                     input logic ag);
        logic [CHAR_W-1:0] c;
        case (sc)
            8'd2:   c = sh ? 8'h21 : 8'h31;
            8'd3:   c = ag ? 8'hB2 : (sh ? 8'h22 : 8'h32);
            8'd4:   c = ag ? 8'hB3 : (sh ? 8'hA7 : 8'h33);
            8'd5:   c = sh ? 8'h24 : 8'h34;
            8'd6:   c = sh ? 8'h25 : 8'h35;
            8'd7:   c = sh ? 8'h26 : 8'h36;
            8'd8:   c = ag ? 8'h7B : (sh ? 8'h2F : 8'h37);
            8'd9:   c = ag ? 8'h5B : (sh ? 8'h28 : 8'h38);
            8'd10:  c = ag ? 8'h5D : (sh ? 8'h29 : 8'h39);
            8'd11:  c = ag ? 8'h7D : (sh ? 8'h3D : 8'h30);
            8'd12:  c = ag ? 8'h5C : (sh ? 8'h3F : 8'hDF);
            8'd13:  c = sh ? CH_ACUTE : CH_GRAVE;
            8'd14:  c = CH_BACK;
            8'd15:  c = 8'd11;
            8'd16:  c = sh ? 8'h51 : 8'h71;
            8'd17:  c = sh ? 8'h57 : 8'h77;
            8'd18:  c = ag ? 8'h80 : (sh ? 8'h45 : 8'h65);
            8'd19:  c = sh ? 8'h52 : 8'h72;
            8'd20:  c = sh ? 8'h54 : 8'h74;
            8'd21:  c = sh ? 8'h5A : 8'h7A;
            8'd22:  c = sh ? 8'h55 : 8'h75;
            8'd23:  c = sh ? 8'h49 : 8'h69;
            8'd24:  c = sh ? 8'h4F : 8'h6F;
            8'd25:  c = sh ? 8'h50 : 8'h70;
            8'd26:  c = sh ? 8'hDC : 8'hFC;
            8'd27:  c = ag ? 8'h7E : (sh ? 8'h2A : 8'h2B);
            8'd28:  c = CH_ENTER;
            8'd30:  c = sh ? 8'h41 : 8'h61;
            8'd31:  c = sh ? 8'h53 : 8'h73;
            8'd32:  c = sh ? 8'h44 : 8'h64;
            8'd33:  c = sh ? 8'h46 : 8'h66;
            8'd34:  c = sh ? 8'h47 : 8'h67;
            8'd35:  c = sh ? 8'h48 : 8'h68;
            8'd36:  c = sh ? 8'h4A : 8'h6A;
            8'd37:  c = sh ? 8'h4B : 8'h6B;
            8'd38:  c = sh ? 8'h4C : 8'h6C;
            8'd39:  c = sh ? 8'hD6 : 8'hF6;
            8'd40:  c = sh ? 8'hC4 : 8'hE4;
            8'd41:  c = sh ? 8'hB0 : CH_CIRC;
            8'd43:  c = sh ? 8'h27 : 8'h23;
            8'd44:  c = sh ? 8'h59 : 8'h79;
            8'd45:  c = sh ? 8'h58 : 8'h78;
            8'd46:  c = sh ? 8'h43 : 8'h63;
            8'd47:  c = sh ? 8'h56 : 8'h76;
            8'd48:  c = sh ? 8'h42 : 8'h62;
            8'd49:  c = sh ? 8'h4E : 8'h6E;
            8'd50:  c = sh ? 8'h4D : 8'h6D;
            8'd51:  c = sh ? 8'h3B : 8'h2C;
            8'd52:  c = sh ? 8'h3A : 8'h2E;
            8'd53:  c = sh ? 8'h5F : 8'h2D;
            8'd55:  c = 8'h2A;
            8'd56:  c = 8'd14;
            8'd57:  c = 8'h20;
            8'd71:  c = 8'h37;
            8'd72:  c = 8'h38;
            8'd73:  c = 8'h39;
            8'd74:  c = 8'h2D;
            8'd75:  c = 8'h34;
            8'd76:  c = 8'h35;
            8'd77:  c = 8'h36;
            8'd78:  c = 8'h2B;
            8'd79:  c = 8'h31;
            8'd80:  c = 8'h32;
            8'd81:  c = 8'h33;
            8'd82:  c = 8'h30;
            8'd86:  c = sh ? 8'h3E : 8'h3C;
            8'd156: c = CH_ENTER;
            8'd181: c = 8'h2F;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    // Vowel plus accent gives the accented letter, anything else the bare accent
    function automatic logic [CHAR_W-1:0] ktd_combine(input logic [CHAR_W-1:0] c,
                                                      input t_accent acc,
                                                      input logic [CHAR_W-1:0] bare);
        logic [CHAR_W-1:0] base;
        logic              hit;
        hit = 1'b1;
        case (c)
            8'h61:   base = 8'hE0;
            8'h65:   base = 8'hE8;
            8'h69:   base = 8'hEC;
            8'h6F:   base = 8'hF2;
            8'h75:   base = 8'hF9;
            8'h41:   base = 8'hC0;
            8'h45:   base = 8'hC8;
            8'h49:   base = 8'hCC;
            8'h4F:   base = 8'hD2;
            8'h55:   base = 8'hD9;
            default: begin
                base = bare;
                hit  = 1'b0;
            end
        endcase
        return hit ? base + CHAR_W'(acc) : base;
    endfunction

endpackage

/* rtl/core/ktd_in_if.sv */
`timescale 1ns / 1ps
// Key event request channel: valid/ready handshake with the event payload.
// Standalone, no dependencies.
interface ktd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] scan_code;
    logic       shift;
    logic       altgr;

    modport source (output valid, kind, scan_code, shift, altgr, input ready);
    modport sink   (input valid, kind, scan_code, shift, altgr, output ready);
endinterface

/* rtl/core/ktd_out_if.sv */
`timescale 1ns / 1ps
// Text-entry action request channel: valid/ready handshake with the result.
// Standalone, no dependencies.
interface ktd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_code;
    logic       entry_active;

    modport source (output valid, action, char_code, entry_active, input ready);
    modport sink   (input valid, action, char_code, entry_active, output ready);
endinterface

/* rtl/core/keyboard_text_entry_decoder_unit.sv */
`timescale 1ns / 1ps
// Keyboard text-entry decoder, top level. Depends on ktd_pkg, ktd_in_if,
// ktd_out_if and ktd_held_set.
// Path: the request is captured in the input register, then one pass of decode
// logic loads the result register once that register is free or draining.
// Throughput: one request per cycle while the sink keeps up; the input register lets
// a new request enter while an earlier result still waits for the sink.
// Reset (synchronous, active low): listening mode, open key 20, listening
// allowed, no pending accents, empty held set, text length zero.
module keyboard_text_entry_decoder_unit #(
    parameter int HELD_KEYS = 8,
    parameter int MAX_TEXT  = 255
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ktd_in_if.sink                         i_in,
    ktd_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ktd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ktd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ktd_pkg::*;

    localparam int LEN_W = $clog2(MAX_TEXT + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TEXT);

    // Configuration registers
    logic [SCAN_W-1:0] r_open_key;
    logic              r_listen;

    // Block state
    t_mode             r_mode, n_mode;
    logic [2:0]        r_accents, n_accents;   // bit0 grave, bit1 acute, bit2 circumflex
    logic [LEN_W-1:0]  r_len, n_len;

    // Input register
    logic              r_in_valid;
    t_kind             r_in_kind;
    logic [SCAN_W-1:0] r_in_sc;
    logic              r_in_shift;
    logic              r_in_altgr;

    // Result register
    logic              r_out_valid;
    t_action           r_out_action;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_active;

    // Datapath
    logic              w_fire;
    logic              w_found;
    logic [CHAR_W-1:0] w_dec;
    logic [CHAR_W-1:0] w_char;
    logic              w_append;
    logic              w_enter;
    t_mode             w_leave;
    t_action           w_action;
    logic [CHAR_W-1:0] w_out_char;
    t_held_cmd         w_held_cmd;

    // Process the held request when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    assign w_dec   = ktd_decode(r_in_sc, r_in_shift, r_in_altgr);
    assign w_leave = r_listen ? MODE_LISTEN : MODE_IDLE;

    ktd_held_set #(
        .HELD_KEYS (HELD_KEYS)
    ) u_held (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (r_in_sc),
        .i_cmd   (w_held_cmd),
        .o_found (w_found)
    );

    // Capture a request whenever the input register has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind  <= t_kind'(i_in.kind);
            r_in_sc    <= i_in.scan_code;
            r_in_shift <= i_in.shift;
            r_in_altgr <= i_in.altgr;
        end
    end

    // Action, character, accents, length and held-set commands
    always_comb begin
        w_action   = ACT_NONE;
        w_out_char = '0;
        w_char     = w_dec;
        w_append   = 1'b0;
        w_enter    = 1'b0;
        w_held_cmd = '0;
        n_accents  = r_accents;
        n_len      = r_len;
        if (w_fire) begin
            case (r_in_kind)
                KIND_RELEASE: begin
                    w_held_cmd.release_key = 1'b1;
                end
                KIND_PRESS: begin
                    if (r_mode == MODE_LISTEN) begin
                        // Open key starts entry; pending accents survive
                        if (r_in_sc == r_open_key) begin
                            w_held_cmd.add = !w_found;
                            n_len          = '0;
                            w_action       = ACT_START;
                        end
                    end else if (r_mode == MODE_ENTRY && !w_found) begin
                        w_held_cmd.add = 1'b1;
                        if (w_dec == CH_GRAVE && !r_accents[0]) begin
                            n_accents[0] = 1'b1;
                        end else if (w_dec == CH_ACUTE && !r_accents[1]) begin
                            n_accents[1] = 1'b1;
                        end else if (w_dec == CH_CIRC && !r_accents[2]) begin
                            n_accents[2] = 1'b1;
                        end else if (r_accents[0]) begin
                            w_char       = ktd_combine(w_dec, ACC_GRAVE, CH_GRAVE);
                            n_accents[0] = 1'b0;
                            w_append     = 1'b1;
                        end else if (r_accents[1]) begin
                            w_char       = ktd_combine(w_dec, ACC_ACUTE, CH_ACUTE);
                            n_accents[1] = 1'b0;
                            w_append     = 1'b1;
                        end else if (r_accents[2]) begin
                            w_char       = ktd_combine(w_dec, ACC_CIRC, CH_CIRC);
                            n_accents[2] = 1'b0;
                            w_append     = 1'b1;
                        end else if (w_dec == CH_ENTER) begin
                            // Finish entry and forget every held key
                            w_action         = ACT_FINISH;
                            w_enter          = 1'b1;
                            w_held_cmd.clear = 1'b1;
                        end else if (w_dec == CH_NONE) begin
                            // Unmapped key: drop
                        end else if (w_dec == CH_BACK) begin
                            if (r_len != '0) begin
                                n_len    = r_len - LEN_W'(1);
                                w_action = ACT_DELETE;
                            end
                        end else begin
                            w_append = 1'b1;
                        end
                        // Saturate the length at the text limit
                        if (w_append && (r_len < LEN_MAX)) begin
                            n_len      = r_len + LEN_W'(1);
                            w_action   = ACT_APPEND;
                            w_out_char = w_char;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Mode changes; configuration writes must arrive only while idle, unchecked
    always_comb begin
        n_mode = r_mode;
        if (i_cfg_we && (i_cfg_index == CFG_LISTEN)) begin
            if (!i_cfg_data[0] && r_mode == MODE_LISTEN) begin
                n_mode = MODE_IDLE;
            end else if (i_cfg_data[0] && r_mode == MODE_IDLE) begin
                n_mode = MODE_LISTEN;
            end
        end else if (w_fire) begin
            case (r_in_kind)
                KIND_ON: begin
                    n_mode = MODE_ENTRY;
                end
                KIND_OFF: begin
                    n_mode = w_leave;
                end
                KIND_PRESS: begin
                    if (r_mode == MODE_LISTEN && r_in_sc == r_open_key) begin
                        n_mode = MODE_ENTRY;
                    end else if (w_enter) begin
                        n_mode = w_leave;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_key <= SCAN_W'(20);
            r_listen   <= 1'b1;
            r_mode     <= MODE_LISTEN;
            r_accents  <= '0;
            r_len      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_OPEN_KEY)) begin
                r_open_key <= i_cfg_data[SCAN_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_LISTEN)) begin
                r_listen <= i_cfg_data[0];
            end
            r_mode    <= n_mode;
            r_accents <= n_accents;
            r_len     <= n_len;
        end
    end

    // Result register: load on fire, drop once the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_action <= w_action;
            r_out_char   <= w_out_char;
            r_out_active <= (n_mode == MODE_ENTRY);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_out_action;
    assign o_out.char_code    = r_out_char;
    assign o_out.entry_active = r_out_active;

endmodule

/* rtl/core/ktd_held_set.sv */
`timescale 1ns / 1ps
// Held-key set: small parallel-compare table of pressed scan codes.
// Depends on ktd_pkg.
module ktd_held_set #(
    parameter int HELD_KEYS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ktd_pkg::SCAN_W-1:0] i_code,
    input  ktd_pkg::t_held_cmd         i_cmd,
    output logic                       o_found
);
    import ktd_pkg::*;

    logic [SCAN_W-1:0]    r_code [HELD_KEYS];
    logic [HELD_KEYS-1:0] r_valid;
    logic [HELD_KEYS-1:0] n_valid;
    logic [HELD_KEYS-1:0] w_hit;
    logic [HELD_KEYS-1:0] w_free;

    always_comb begin
        for (int i = 0; i < HELD_KEYS; i++) begin
            w_hit[i] = r_valid[i] && (r_code[i] == i_code);
        end
    end

    assign o_found = |w_hit;

    // First free slot, one-hot; none when full
    always_comb begin
        w_free = '0;
        for (int i = 0; i < HELD_KEYS; i++) begin
            if (!r_valid[i] && (w_free == '0)) begin
                w_free[i] = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = '0;
        end else if (i_cmd.release_key) begin
            n_valid = r_valid & ~w_hit;
        end else if (i_cmd.add) begin
            n_valid = r_valid | w_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HELD_KEYS; i++) begin
            if (i_cmd.add && w_free[i]) begin
                r_code[i] <= i_code;
            end
        end
    end

endmodule

/* sim/keyboard_text_entry_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for keyboard_text_entry_decoder_unit: a stimulus table, then
// random typing sessions under several idling phases, checked against an in-bench model.
// Depends on ktd_pkg, ktd_in_if, ktd_out_if and the RTL under rtl/core.
module keyboard_text_entry_decoder_unit_tb;
    import ktd_pkg::*;

    localparam int HELD_KEYS   = 8;
    localparam int MAX_TEXT    = 255;
    localparam int CYCLE_LIMIT = 400000;

    // Key rows of the German layout, first key in the top byte
    localparam logic [8*10-1:0] ROW_Q      = "qwertzuiop";
    localparam logic [8*9-1:0]  ROW_A      = "asdfghjkl";
    localparam logic [8*7-1:0]  ROW_Y      = "yxcvbnm";
    localparam logic [8*12-1:0] ROW_KEYPAD = "789-456+1230";
    localparam logic [8*5-1:0]  VOWELS     = "aeiou";
    localparam logic [8*5-1:0]  GRAVE_BASE = 40'hE0E8ECF2F9;
    // Keys that drive typing sessions: vowels, dead accents, backspace, AltGr keys, space and other keys
    localparam logic [8*24-1:0] KEY_POOL = {8'd30, 8'd18, 8'd23, 8'd24, 8'd22, 8'd13,
                                            8'd13, 8'd41, 8'd41, 8'd14, 8'd14, 8'd15,
                                            8'd56, 8'd3,  8'd4,  8'd8,  8'd12, 8'd18,
                                            8'd27, 8'd57, 8'd2,  8'd50, 8'd86, 8'd181};

    typedef struct packed {
        t_action    action;
        logic [7:0] char_code;
        logic       entry_active;
    } t_text_action;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   scan;
        logic         sh;
        logic         ag;
        logic         typed;
        t_text_action want;
    } t_row;

    localparam t_text_action NO_WANT = '{ACT_NONE, 8'h00, 1'b0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ktd_in_if  key_ch ();
    ktd_out_if act_ch ();

    keyboard_text_entry_decoder_unit #(
        .HELD_KEYS(HELD_KEYS),
        .MAX_TEXT (MAX_TEXT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (key_ch),
        .o_out      (act_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Model state
    t_mode      mode_now;
    logic [2:0] accents_due;    // bit 0 grave, bit 1 acute, bit 2 circumflex
    logic [7:0] held_key [HELD_KEYS];
    logic       held_ok  [HELD_KEYS];
    int         text_len;
    logic [7:0] open_key_q;
    logic       listen_ok;

    t_text_action due [$];      // actions owed by the block, oldest first
    t_text_action got, pred;
    logic         row_typed;    // sideband of the request now on the channel
    t_text_action row_want;
    int           requests_taken;
    int           mismatches;
    int           cycle_count;
    int           send_gap_pct;
    int           sink_stall_pct;

    // Directed sessions. Typed rows carry their action; the rest go to the model.
    t_row plan [27] = '{
        '{KIND_PRESS,   8'd0,   1'b0, 1'b0, 1'b1, '{ACT_NONE,   8'h00, 1'b0}},
        '{KIND_PRESS,   8'd20,  1'b1, 1'b1, 1'b1, '{ACT_START,  8'h00, 1'b1}},
        '{KIND_PRESS,   8'd20,  1'b0, 1'b0, 1'b1, '{ACT_NONE,   8'h00, 1'b1}},
        '{KIND_PRESS,   8'd14,  1'b0, 1'b0, 1'b1, '{ACT_NONE,   8'h00, 1'b1}},
        '{KIND_PRESS,   8'd30,  1'b0, 1'b0, 1'b1, '{ACT_APPEND, 8'h61, 1'b1}},
        '{KIND_PRESS,   8'd13,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd18,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_RELEASE, 8'd13,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd13,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd22,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd41,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_RELEASE, 8'd41,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd41,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd255, 1'b1, 1'b1, 1'b1, '{ACT_NONE,   8'h00, 1'b1}},
        '{KIND_PRESS,   8'd15,  1'b0, 1'b0, 1'b1, '{ACT_APPEND, 8'h0B, 1'b1}},
        '{KIND_PRESS,   8'd56,  1'b0, 1'b0, 1'b1, '{ACT_APPEND, 8'h0E, 1'b1}},
        '{KIND_RELEASE, 8'd18,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd18,  1'b0, 1'b1, 1'b1, '{ACT_APPEND, 8'h80, 1'b1}},
        '{KIND_RELEASE, 8'd14,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd14,  1'b0, 1'b0, 1'b1, '{ACT_DELETE, 8'h00, 1'b1}},
        '{KIND_OFF,     8'd0,   1'b0, 1'b0, 1'b1, '{ACT_NONE,   8'h00, 1'b0}},
        '{KIND_ON,      8'd0,   1'b0, 1'b0, 1'b1, '{ACT_NONE,   8'h00, 1'b1}},
        '{KIND_PRESS,   8'd28,  1'b0, 1'b0, 1'b1, '{ACT_FINISH, 8'h00, 1'b0}},
        '{KIND_PRESS,   8'd20,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd13,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_PRESS,   8'd156, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{KIND_OFF,     8'd255, 1'b1, 1'b1, 1'b0, NO_WANT}
    };

    // Scan code plus modifier levels to a Windows-1252 code
    function automatic logic [7:0] key_to_char(input logic [7:0] sc, input logic sh,
                                               input logic ag);
        logic [15:0] pair;  // {shifted, plain}
        logic [7:0]  c;
        pair = {CH_NONE, CH_NONE};
        if (sc >= 16 && sc <= 25) begin
            pair[7:0] = ROW_Q[8*(25-sc) +: 8];
            pair[15:8] = pair[7:0] - 8'h20;
        end else if (sc >= 30 && sc <= 38) begin
            pair[7:0] = ROW_A[8*(38-sc) +: 8];
            pair[15:8] = pair[7:0] - 8'h20;
        end else if (sc >= 44 && sc <= 50) begin
            pair[7:0] = ROW_Y[8*(50-sc) +: 8];
            pair[15:8] = pair[7:0] - 8'h20;
        end else if (sc >= 71 && sc <= 82) begin
            pair = {2{ROW_KEYPAD[8*(82-sc) +: 8]}};
        end else begin
            case (sc)
                8'd2:          pair = "!1";
                8'd3:          pair = "\"2";
                8'd4:          pair = {8'hA7, "3"};
                8'd5:          pair = "$4";
                8'd6:          pair = "%5";
                8'd7:          pair = "&6";
                8'd8:          pair = "/7";
                8'd9:          pair = "(8";
                8'd10:         pair = ")9";
                8'd11:         pair = "=0";
                8'd12:         pair = {"?", 8'hDF};
                8'd13:         pair = {CH_ACUTE, CH_GRAVE};
                8'd14:         pair = {2{CH_BACK}};
                8'd15:         pair = {2{8'd11}};
                8'd26:         pair = 16'hDCFC;
                8'd27:         pair = "*+";
                8'd28, 8'd156: pair = {2{CH_ENTER}};
                8'd39:         pair = 16'hD6F6;
                8'd40:         pair = 16'hC4E4;
                8'd41:         pair = {8'hB0, CH_CIRC};
                8'd43:         pair = "'#";
                8'd51:         pair = ";,";
                8'd52:         pair = ":.";
                8'd53:         pair = "_-";
                8'd55:         pair = "**";
                8'd56:         pair = {2{8'd14}};
                8'd57:         pair = "  ";
                8'd86:         pair = "><";
                8'd181:        pair = "//";
                default:       ;
            endcase
        end
        c = sh ? pair[15:8] : pair[7:0];
        // AltGr level wins over shift where the key has one
        if (ag) begin
            case (sc)
                8'd3:    c = 8'hB2;
                8'd4:    c = 8'hB3;
                8'd8:    c = "{";
                8'd9:    c = "[";
                8'd10:   c = "]";
                8'd11:   c = "}";
                8'd12:   c = "\\";
                8'd18:   c = 8'h80;
                8'd27:   c = "~";
                default: ;
            endcase
        end
        return c;
    endfunction

    // Dead accent on a vowel gives the accented letter, on anything else the bare accent
    function automatic logic [7:0] accented(input logic [7:0] c, input t_accent acc,
                                            input logic [7:0] bare);
        logic [7:0] v, base, r;
        int         i;
        r = bare;
        for (i = 0; i < 5; i++) begin
            v = VOWELS[8*(4-i) +: 8];
            base = GRAVE_BASE[8*(4-i) +: 8] + 8'(acc);
            if (c == v)
                r = base;
            else if (c == v - 8'h20)
                r = base - 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_held(input logic [7:0] sc);
        logic hit;
        int   i;
        hit = 1'b0;
        for (i = 0; i < HELD_KEYS; i++)
            if (held_ok[i] && held_key[i] == sc)
                hit = 1'b1;
        return hit;
    endfunction

    // Record in the first free slot; drop silently when the set is full
    function automatic void hold_key(input logic [7:0] sc);
        logic done;
        int   i;
        done = 1'b0;
        for (i = 0; i < HELD_KEYS; i++) begin
            if (!done && !held_ok[i]) begin
                held_ok[i] = 1'b1;
                held_key[i] = sc;
                done = 1'b1;
            end
        end
    endfunction

    task automatic clear_model();
        int i;
        mode_now = MODE_LISTEN;
        accents_due = 3'b000;
        text_len = 0;
        open_key_q = 8'd20;
        listen_ok = 1'b1;
        for (i = 0; i < HELD_KEYS; i++) begin
            held_ok[i] = 1'b0;
            held_key[i] = 8'd0;
        end
    endtask

    // Advance the text-entry model by one key event and return its action
    task automatic step_text_entry(input t_kind k, input logic [7:0] sc, input logic sh,
                                   input logic ag, output t_text_action res);
        logic [7:0] c;
        logic       add_char;
        int         i;
        res = NO_WANT;
        add_char = 1'b0;
        case (k)
            KIND_RELEASE: begin
                for (i = 0; i < HELD_KEYS; i++)
                    if (held_ok[i] && held_key[i] == sc)
                        held_ok[i] = 1'b0;
            end
            KIND_ON:  mode_now = MODE_ENTRY;
            KIND_OFF: mode_now = listen_ok ? MODE_LISTEN : MODE_IDLE;
            KIND_PRESS: begin
                if (mode_now == MODE_LISTEN) begin
                    // open key starts entry; pending accents survive
                    if (sc == open_key_q) begin
                        if (!is_held(sc))
                            hold_key(sc);
                        mode_now = MODE_ENTRY;
                        text_len = 0;
                        res.action = ACT_START;
                    end
                end else if (mode_now == MODE_ENTRY && !is_held(sc)) begin
                    c = key_to_char(sc, sh, ag);
                    hold_key(sc);
                    if (c == CH_GRAVE && !accents_due[0]) begin
                        accents_due[0] = 1'b1;
                    end else if (c == CH_ACUTE && !accents_due[1]) begin
                        accents_due[1] = 1'b1;
                    end else if (c == CH_CIRC && !accents_due[2]) begin
                        accents_due[2] = 1'b1;
                    end else if (accents_due[0]) begin
                        c = accented(c, ACC_GRAVE, CH_GRAVE);
                        accents_due[0] = 1'b0;
                        add_char = 1'b1;
                    end else if (accents_due[1]) begin
                        c = accented(c, ACC_ACUTE, CH_ACUTE);
                        accents_due[1] = 1'b0;
                        add_char = 1'b1;
                    end else if (accents_due[2]) begin
                        c = accented(c, ACC_CIRC, CH_CIRC);
                        accents_due[2] = 1'b0;
                        add_char = 1'b1;
                    end else if (c == CH_ENTER) begin
                        res.action = ACT_FINISH;
                        mode_now = listen_ok ? MODE_LISTEN : MODE_IDLE;
                        for (i = 0; i < HELD_KEYS; i++)
                            held_ok[i] = 1'b0;
                    end else if (c == CH_BACK) begin
                        if (text_len > 0) begin
                            text_len--;
                            res.action = ACT_DELETE;
                        end
                    end else if (c != CH_NONE) begin
                        add_char = 1'b1;
                    end
                    // full text swallows the append
                    if (add_char && text_len < MAX_TEXT) begin
                        text_len++;
                        res.action = ACT_APPEND;
                        res.char_code = c;
                    end
                end
            end
            default: ;
        endcase
        res.entry_active = (mode_now == MODE_ENTRY);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keyboard_text_entry_decoder_unit_tb: FAIL");
            $finish;
        end
    end

    // Receiver: stall at the configured rate, change only at the falling edge
    always @(negedge i_clk)
        act_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);

    // At each rising edge: check a delivered action first, then model an accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && act_ch.valid && act_ch.ready) begin
            got = '{t_action'(act_ch.action), act_ch.char_code, act_ch.entry_active};
            if (due.size() == 0) begin
                $display("%0t: action %0d char %02h active %0b with no request outstanding",
                         $time, got.action, got.char_code, got.entry_active);
                mismatches++;
            end else begin
                pred = due.pop_front();
                if (got.action !== pred.action) begin
                    $display("%0t: action expected %0d actual %0d",
                             $time, pred.action, got.action);
                    mismatches++;
                end
                if (got.char_code !== pred.char_code) begin
                    $display("%0t: char_code expected %02h actual %02h",
                             $time, pred.char_code, got.char_code);
                    mismatches++;
                end
                if (got.entry_active !== pred.entry_active) begin
                    $display("%0t: entry_active expected %0b actual %0b",
                             $time, pred.entry_active, got.entry_active);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            step_text_entry(t_kind'(key_ch.kind), key_ch.scan_code, key_ch.shift,
                            key_ch.altgr, pred);
            due.insert(due.size(), row_typed ? row_want : pred);
            requests_taken++;
        end
    end

    // Offer one request from a falling edge; return at the falling edge after it is taken
    task automatic send_request(input t_kind k, input logic [7:0] sc, input logic sh,
                                input logic ag, input logic typed, input t_text_action want);
        int mark;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            key_ch.valid = 1'b0;
            key_ch.scan_code = 8'($urandom);
            @(negedge i_clk);
        end
        key_ch.valid = 1'b1;
        key_ch.kind = k;
        key_ch.scan_code = sc;
        key_ch.shift = sh;
        key_ch.altgr = ag;
        row_typed = typed;
        row_want = want;
        mark = requests_taken;
        do @(negedge i_clk); while (requests_taken == mark);
    endtask

    task automatic key_event(input t_kind k, input logic [7:0] sc, input logic sh,
                             input logic ag);
        send_request(k, sc, sh, ag, 1'b0, NO_WANT);
    endtask

    // Hold off new requests until every owed action has come back
    task automatic drain_actions();
        key_ch.valid = 1'b0;
        while (due.size() != 0)
            @(negedge i_clk);
    endtask

    // Write while idle, and mirror the side effect of the listen switch
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_actions();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        if (idx == CFG_OPEN_KEY) begin
            open_key_q = data;
        end else begin
            listen_ok = data[0];
            if (!listen_ok && mode_now == MODE_LISTEN)
                mode_now = MODE_IDLE;
            else if (listen_ok && mode_now == MODE_IDLE)
                mode_now = MODE_LISTEN;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_key();
        int n;
        n = $urandom_range(0, 23);
        return KEY_POOL[8*n +: 8];
    endfunction

    // One session: open, type, then finish, switch off or leave it open
    task automatic type_session(input int len);
        int r;
        if (mode_now == MODE_LISTEN && $urandom_range(0, 3) != 0)
            key_event(KIND_PRESS, open_key_q, 1'($urandom), 1'($urandom));
        else
            key_event(KIND_ON, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                key_event(KIND_PRESS, pick_key(), 1'($urandom), $urandom_range(0, 3) == 0);
            else if (r < 75)
                key_event(KIND_RELEASE, pick_key(), 1'($urandom), 1'($urandom));
            else if (r < 85)
                key_event(KIND_RELEASE, open_key_q, 1'($urandom), 1'($urandom));
            else
                key_event(KIND_PRESS, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 65)
            key_event(KIND_PRESS, r[0] ? 8'd28 : 8'd156, 1'($urandom), 1'($urandom));
        else if (r < 85)
            key_event(KIND_OFF, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Mostly sessions, some raw noise, until the phase budget is taken
    task automatic run_phase(input int budget);
        int start;
        start = requests_taken;
        while (requests_taken - start < budget) begin
            if ($urandom_range(0, 99) < 15)
                key_event(t_kind'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                          1'($urandom));
            else
                type_session($urandom_range(1, 14));
        end
    endtask

    // Finish an entry, fill the held set, saturate the text with one unheld key, then delete and finish
    task automatic fill_text();
        int i;
        key_event(KIND_ON, 8'd0, 1'b0, 1'b0);
        repeat (4) begin
            key_event(KIND_RELEASE, 8'd28, 1'b0, 1'b0);
            key_event(KIND_PRESS, 8'd28, 1'b0, 1'b0);
        end
        key_event(KIND_ON, 8'd0, 1'b0, 1'b0);
        for (i = 0; i < HELD_KEYS; i++)
            key_event(KIND_PRESS, 8'(16 + i), 1'($urandom), 1'b0);
        repeat (MAX_TEXT + 6)
            key_event(KIND_PRESS, 8'd35, 1'($urandom), 1'b0);
        key_event(KIND_PRESS, 8'd14, 1'b0, 1'b0);
        key_event(KIND_PRESS, 8'd28, 1'b0, 1'b0);
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_OPEN_KEY;
        i_cfg_data = '0;
        key_ch.valid = 1'b0;
        key_ch.kind = KIND_PRESS;
        key_ch.scan_code = 8'd0;
        key_ch.shift = 1'b0;
        key_ch.altgr = 1'b0;
        act_ch.ready = 1'b0;
        row_typed = 1'b0;
        row_want = NO_WANT;
        requests_taken = 0;
        mismatches = 0;
        cycle_count = 0;
        send_gap_pct = 0;
        sink_stall_pct = 0;
        clear_model();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, no idling
        for (i = 0; i < 27; i++)
            send_request(plan[i].kind, plan[i].scan, plan[i].sh, plan[i].ag,
                         plan[i].typed, plan[i].want);

        // Lowest open key, saturate the text, then sessions without idling
        write_register(CFG_OPEN_KEY, 8'd0);
        write_register(CFG_LISTEN, 8'd1);
        fill_text();
        run_phase(50);

        // Highest open key, listening off, sender mostly idle
        send_gap_pct = 83;
        write_register(CFG_OPEN_KEY, 8'd255);
        write_register(CFG_LISTEN, 8'd0);
        run_phase(45);

        // Random open key, listening back on, receiver mostly stalled;
        // drain halfway so the block runs dry mid-phase
        send_gap_pct = 0;
        sink_stall_pct = 83;
        write_register(CFG_LISTEN, 8'd1);
        write_register(CFG_OPEN_KEY, 8'($urandom));
        run_phase(25);
        drain_actions();
        run_phase(25);

        // Enter doubles as the open key, both sides idling
        send_gap_pct = 21;
        sink_stall_pct = 21;
        write_register(CFG_OPEN_KEY, 8'd28);
        run_phase(45);

        // Toggle listening across idle, new open key
        write_register(CFG_LISTEN, 8'd0);
        write_register(CFG_OPEN_KEY, 8'd18);
        run_phase(25);
        write_register(CFG_LISTEN, 8'd1);
        run_phase(25);

        drain_actions();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("keyboard_text_entry_decoder_unit_tb: PASS");
        else
            $display("keyboard_text_entry_decoder_unit_tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ktd_pkg.sv
rtl/core/ktd_in_if.sv
rtl/core/ktd_out_if.sv
rtl/core/ktd_held_set.sv
rtl/core/keyboard_text_entry_decoder_unit.sv
sim/keyboard_text_entry_decoder_unit_tb.sv
